[rtl/psar_pkg.sv]
// Shared opcodes, status codes, register indexes and controller/datapath types.
`default_nettype none
package psar_pkg;

    localparam logic [1:0] OP_AGE      = 2'd0;
    localparam logic [1:0] OP_TOUCH    = 2'd1;
    localparam logic [1:0] OP_ACTIVATE = 2'd2;
    localparam logic [1:0] OP_CLEAR    = 2'd3;

    localparam logic [2:0] ST_DONE   = 3'd0;
    localparam logic [2:0] ST_HIT    = 3'd1;
    localparam logic [2:0] ST_MISS   = 3'd2;
    localparam logic [2:0] ST_HELD   = 3'd3;
    localparam logic [2:0] ST_FREE   = 3'd4;
    localparam logic [2:0] ST_EVICT  = 3'd5;
    localparam logic [2:0] ST_REJECT = 3'd6;

    localparam logic CFG_ACTIVE_SLOTS    = 1'b0;
    localparam logic CFG_EVICT_THRESHOLD = 1'b1;

    localparam logic [4:0]  ACTIVE_SLOTS_RST    = 5'd16;
    localparam logic [15:0] EVICT_THRESHOLD_RST = 16'd100;

    typedef struct packed {
        logic load;    // latch the accepted beat, restart scan
        logic rd;      // read slot at scan index, advance
        logic finish;  // resolve op, do final write, load output register
    } t_ctl_cmd;

    typedef struct packed {
        logic n_zero;   // no slot in use
        logic rd_last;  // scan index is at the last slot in use
        logic out_busy; // output register holds a beat not taken this cycle
    } t_ctl_sts;

endpackage
`default_nettype wire

[rtl/psar_ctrl.sv]
// Sequencer for the slot table: accept, scan, drain, finish.
`default_nettype none
module psar_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire logic [1:0]          i_opcode,
    output psar_pkg::t_ctl_cmd       o_cmd,
    input  wire psar_pkg::t_ctl_sts  i_sts
);
    import psar_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_opcode == OP_CLEAR || i_sts.n_zero) begin
                        n_state = S_FINISH;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (i_sts.rd_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_FINISH;
            end
            S_FINISH: begin
                if (!i_sts.out_busy) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_cmd.load   = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.rd     = (r_state == S_SCAN);
    assign o_cmd.finish = (r_state == S_FINISH) && !i_sts.out_busy;

endmodule
`default_nettype wire

[rtl/psar_dp.sv]
// Slot table datapath: config, id/age memories, valid bits, scan trackers, output register.
`default_nettype none
module psar_dp #(
    parameter int SLOT_COUNT = 16,
    parameter int ID_BITS    = 16,
    parameter int AGE_BITS   = 16
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire logic                i_cfg_idx,
    input  wire logic [15:0]         i_cfg_data,
    input  wire logic [1:0]          i_opcode,
    input  wire logic [15:0]         i_probe_id,
    input  wire psar_pkg::t_ctl_cmd  i_cmd,
    output psar_pkg::t_ctl_sts       o_sts,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output logic [2:0]               o_status,
    output logic [3:0]               o_slot,
    output logic [15:0]              o_evicted_probe,
    output logic                     o_evicted_valid
);
    import psar_pkg::*;

    localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CW = $clog2(SLOT_COUNT + 1);
    localparam logic [CW+4:0] SLOTS_EXT = (CW+5)'(SLOT_COUNT);
    localparam logic [AGE_BITS-1:0] AGE_MAX = '1;

    // config
    logic [4:0]  r_active;
    logic [15:0] r_thresh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= ACTIVE_SLOTS_RST;
            r_thresh <= EVICT_THRESHOLD_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ACTIVE_SLOTS:    r_active <= i_cfg_data[4:0];
                CFG_EVICT_THRESHOLD: r_thresh <= i_cfg_data;
                default:             r_active <= r_active;
            endcase
        end
    end

    // slots in use, clamped to the table size
    logic [CW+4:0] act_ext;
    logic [CW-1:0] n_use;
    assign act_ext = {{CW{1'b0}}, r_active};
    assign n_use   = (act_ext > SLOTS_EXT) ? CW'(SLOT_COUNT) : act_ext[CW-1:0];

    // latched beat
    logic [1:0]          r_op;
    logic [ID_BITS-1:0]  r_id;
    logic [ID_BITS+15:0] in_id_ext;
    assign in_id_ext = {{ID_BITS{1'b0}}, i_probe_id};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op <= i_opcode;
            r_id <= in_id_ext[ID_BITS-1:0];
        end
    end

    // scan index
    logic [SW-1:0]    r_rd_idx;
    logic [SW+CW-1:0] rd_nxt;
    assign rd_nxt = (SW+CW)'(r_rd_idx) + (SW+CW)'(1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rd_idx <= '0;
        end else if (i_cmd.rd) begin
            r_rd_idx <= r_rd_idx + SW'(1);
        end
    end

    assign o_sts.n_zero  = (n_use == '0);
    assign o_sts.rd_last = (rd_nxt == (SW+CW)'(n_use));

    // memories
    logic [ID_BITS-1:0]  id_mem  [SLOT_COUNT];
    logic [AGE_BITS-1:0] age_mem [SLOT_COUNT];
    logic [ID_BITS-1:0]  r_id_q;
    logic [AGE_BITS-1:0] r_age_q;
    logic                id_we;
    logic [SW-1:0]       id_wa;
    logic                age_we;
    logic [SW-1:0]       age_wa;
    logic [AGE_BITS-1:0] age_wd;

    always_ff @(posedge i_clk) begin
        if (id_we) begin
            id_mem[id_wa] <= r_id;
        end
        if (i_cmd.rd) begin
            r_id_q <= id_mem[r_rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (age_we) begin
            age_mem[age_wa] <= age_wd;
        end
        if (i_cmd.rd) begin
            r_age_q <= age_mem[r_rd_idx];
        end
    end

    // compare stage, in the cycle after the read
    logic          r_cmp_vld;
    logic [SW-1:0] r_cmp_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp_vld <= 1'b0;
        end else begin
            r_cmp_vld <= i_cmd.rd;
        end
        r_cmp_idx <= r_rd_idx;
    end

    logic [SLOT_COUNT-1:0] r_valid;
    logic                  cmp_slot_vld;
    logic                  cmp_match;
    assign cmp_slot_vld = r_valid[r_cmp_idx];
    assign cmp_match    = cmp_slot_vld && (r_id_q == r_id);

    // trackers
    logic                r_hit_fnd;
    logic [SW-1:0]       r_hit_idx;
    logic                r_free_fnd;
    logic [SW-1:0]       r_free_idx;
    logic                r_old_fnd;
    logic [SW-1:0]       r_old_idx;
    logic [AGE_BITS-1:0] r_old_age;
    logic [ID_BITS-1:0]  r_old_id;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.load) begin
            r_hit_fnd  <= 1'b0;
            r_free_fnd <= 1'b0;
            r_old_fnd  <= 1'b0;
        end else if (r_cmp_vld) begin
            if (cmp_match && !r_hit_fnd) begin
                r_hit_fnd <= 1'b1;
                r_hit_idx <= r_cmp_idx;
            end
            if (!cmp_slot_vld && !r_free_fnd) begin
                r_free_fnd <= 1'b1;
                r_free_idx <= r_cmp_idx;
            end
            // strict compare keeps the lowest index on ties
            if (cmp_slot_vld && (!r_old_fnd || r_age_q > r_old_age)) begin
                r_old_fnd <= 1'b1;
                r_old_idx <= r_cmp_idx;
                r_old_age <= r_age_q;
                r_old_id  <= r_id_q;
            end
        end
    end

    // resolve
    logic [2:0]           fin_status;
    logic [SW-1:0]        fin_slot;
    logic                 fin_ev;
    logic                 fin_place;
    logic                 fin_zero_age;
    logic [SW-1:0]        fin_tgt;
    logic [AGE_BITS+15:0] old_age_ext;
    logic [AGE_BITS+15:0] thresh_ext;
    assign old_age_ext = (AGE_BITS+16)'(r_old_age);
    assign thresh_ext  = (AGE_BITS+16)'(r_thresh);

    always_comb begin
        fin_status   = ST_DONE;
        fin_slot     = '0;
        fin_ev       = 1'b0;
        fin_place    = 1'b0;
        fin_zero_age = 1'b0;
        fin_tgt      = '0;
        case (r_op)
            OP_AGE: begin
                fin_status = ST_DONE;
            end
            OP_TOUCH: begin
                if (r_hit_fnd) begin
                    fin_status   = ST_HIT;
                    fin_slot     = r_hit_idx;
                    fin_zero_age = 1'b1;
                    fin_tgt      = r_hit_idx;
                end else begin
                    fin_status = ST_MISS;
                end
            end
            OP_ACTIVATE: begin
                if (r_hit_fnd) begin
                    fin_status = ST_HELD;
                    fin_slot   = r_hit_idx;
                end else if (r_free_fnd) begin
                    fin_status = ST_FREE;
                    fin_slot   = r_free_idx;
                    fin_place  = 1'b1;
                    fin_tgt    = r_free_idx;
                end else if (r_old_fnd && old_age_ext > thresh_ext) begin
                    fin_status = ST_EVICT;
                    fin_slot   = r_old_idx;
                    fin_ev     = 1'b1;
                    fin_place  = 1'b1;
                    fin_tgt    = r_old_idx;
                end else begin
                    fin_status = ST_REJECT;
                end
            end
            OP_CLEAR: begin
                fin_status = ST_DONE;
            end
            default: begin
                fin_status = ST_DONE;
            end
        endcase
    end

    // write port arbitration: age increments during an age scan, final write at finish
    always_comb begin
        id_we  = i_cmd.finish && fin_place;
        id_wa  = fin_tgt;
        age_we = 1'b0;
        age_wa = r_cmp_idx;
        age_wd = (r_age_q == AGE_MAX) ? r_age_q : r_age_q + AGE_BITS'(1);
        if (i_cmd.finish && (fin_place || fin_zero_age)) begin
            age_we = 1'b1;
            age_wa = fin_tgt;
            age_wd = '0;
        end else if (r_cmp_vld && r_op == OP_AGE && cmp_slot_vld) begin
            age_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_cmd.finish && r_op == OP_CLEAR) begin
            r_valid <= '0;
        end else if (i_cmd.finish && fin_place) begin
            r_valid[fin_tgt] <= 1'b1;
        end
    end

    // output register
    logic                r_out_vld;
    logic [2:0]          r_out_status;
    logic [3:0]          r_out_slot;
    logic [15:0]         r_out_ev_id;
    logic                r_out_ev_vld;
    logic [SW+3:0]       slot_ext;
    logic [ID_BITS+15:0] ev_id_ext;
    assign slot_ext  = {4'b0000, fin_slot};
    assign ev_id_ext = {16'h0000, r_old_id};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
        if (i_cmd.finish) begin
            r_out_status <= fin_status;
            r_out_slot   <= slot_ext[3:0];
            r_out_ev_id  <= fin_ev ? ev_id_ext[15:0] : 16'h0000;
            r_out_ev_vld <= fin_ev;
        end
    end

    assign o_sts.out_busy  = r_out_vld && !i_out_ready;
    assign o_out_valid     = r_out_vld;
    assign o_status        = r_out_status;
    assign o_slot          = r_out_slot;
    assign o_evicted_probe = r_out_ev_id;
    assign o_evicted_valid = r_out_ev_vld;

`ifndef SYNTHESIS
    a_cmp_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cmp_vld |-> ((SW+CW)'(r_cmp_idx) < (SW+CW)'(n_use)))
        else $error("compare stage beyond slots in use");

    a_place_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.finish && fin_place) |=> r_valid[$past(fin_tgt)])
        else $error("placed slot not marked valid");

    a_evict_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.finish && fin_status == ST_EVICT) |-> (!r_free_fnd && !r_hit_fnd))
        else $error("eviction with a free slot or a held id");

    a_ev_flag_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_evicted_valid) |-> (o_status == ST_EVICT))
        else $error("evicted flag on a non-evict beat");
`endif

endmodule
`default_nettype wire

[rtl/probe_slot_age_replacement.sv]
// One beat is handled at a time: the next is accepted only in idle, after the last one finished;
// clear, or any op with no slot in use, skips the scan.
// The scan reads one slot per cycle through the single read port of the id/age memories.
// The next beat is accepted while a result still waits in the output register.
// Reset (synchronous, active low): all slots empty, active_slots 16, threshold 100;
// no clearing pass, the table is usable right after reset.
`default_nettype none
module probe_slot_age_replacement #(
    parameter int SLOT_COUNT = 16,
    parameter int ID_BITS    = 16,
    parameter int AGE_BITS   = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [15:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [1:0]  i_opcode,
    input  wire logic [15:0] i_probe_id,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [2:0]       o_status,
    output logic [3:0]       o_slot,
    output logic [15:0]      o_evicted_probe,
    output logic             o_evicted_valid
);
    import psar_pkg::*;

    t_ctl_cmd cmd;
    t_ctl_sts sts;

    psar_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_opcode   (i_opcode),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    psar_dp #(
        .SLOT_COUNT (SLOT_COUNT),
        .ID_BITS    (ID_BITS),
        .AGE_BITS   (AGE_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_opcode        (i_opcode),
        .i_probe_id      (i_probe_id),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_status        (o_status),
        .o_slot          (o_slot),
        .o_evicted_probe (o_evicted_probe),
        .o_evicted_valid (o_evicted_valid)
    );

endmodule
`default_nettype wire

[dv/tb_probe_slot_age_replacement.sv]
// Self-checking testbench for the probe slot table with age-based replacement.
`timescale 1ns / 1ps
module tb_probe_slot_age_replacement;
    import psar_pkg::*;

    localparam int SLOTS = 16;
    localparam logic [15:0] AGE_MAX = 16'hFFFF;
    localparam int SETTLE = SLOTS + 4;         // worst-case latency plus margin
    localparam int HOLD_CYCLES = 400;          // long output back-pressure stretch
    localparam int STALL_LIMIT = 4000;         // cycles without any beat moving
    localparam int PHASES = 10;
    localparam int DIR_ROWS = 27;
    localparam int MAX_PRINTS = 20;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  slot;
        logic [15:0] ev_probe;
        logic        ev_valid;
    } t_probe_res;

    typedef enum logic {ROW_OP, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind   kind;
        logic [1:0]  op;
        logic        cidx;
        logic [15:0] val;     // probe id, or register data for a config row
        logic        chk;     // typed expectation present
        t_probe_res  res;
    } t_dir_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_idx = CFG_ACTIVE_SLOTS;
    logic [15:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic [1:0]  i_opcode = OP_AGE;
    logic [15:0] i_probe_id = '0;
    logic        i_out_ready = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [2:0]  o_status;
    logic [3:0]  o_slot;
    logic [15:0] o_evicted_probe;
    logic        o_evicted_valid;

    probe_slot_age_replacement u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_opcode        (i_opcode),
        .i_probe_id      (i_probe_id),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_status        (o_status),
        .o_slot          (o_slot),
        .o_evicted_probe (o_evicted_probe),
        .o_evicted_valid (o_evicted_valid)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // shadow of the slot table and registers
    logic [15:0] tbl_id [SLOTS];
    logic        tbl_valid [SLOTS];
    logic [15:0] tbl_age [SLOTS];
    logic [4:0]  cfg_active = ACTIVE_SLOTS_RST;
    logic [15:0] cfg_thresh = EVICT_THRESHOLD_RST;

    t_probe_res pending_res [$];

    int err_cnt = 0;
    int sent_cnt = 0;
    int rcvd_cnt = 0;
    int evict_cnt = 0;
    int reject_cnt = 0;
    int hit_cnt = 0;
    int fill_cnt = 0;
    int send_idle_pct = 0;
    int stall_pct = 0;
    int hold_req = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int quiet_cycles = 0;

    int ph_active [PHASES] = '{4, 16, 1, 8, 16, 2, 31, 0, 16, 5};
    int ph_thresh [PHASES] = '{0, 3, 0, 1, 100, 5, 2, 7, 65535, 0};
    int ph_items  [PHASES] = '{200, 250, 120, 200, 200, 150, 150, 60, 120, 200};

    t_dir_row dir_tab [DIR_ROWS] = '{
        '{ROW_OP,  OP_TOUCH,    CFG_ACTIVE_SLOTS,    16'h1234, 1'b1, '{ST_MISS,   4'd0, 16'h0000, 1'b0}},
        '{ROW_OP,  OP_ACTIVATE, CFG_ACTIVE_SLOTS,    16'h0000, 1'b1, '{ST_FREE,   4'd0, 16'h0000, 1'b0}},
        '{ROW_OP,  OP_ACTIVATE, CFG_ACTIVE_SLOTS,    16'hFFFF, 1'b1, '{ST_FREE,   4'd1, 16'h0000, 1'b0}},
        '{ROW_OP,  OP_ACTIVATE, CFG_ACTIVE_SLOTS,    16'hFFFF, 1'b0, '0},
        '{ROW_OP,  OP_TOUCH,    CFG_ACTIVE_SLOTS,    16'hFFFF, 1'b0, '0},
        '{ROW_OP,  OP_AGE,      CFG_ACTIVE_SLOTS,    16'h0000, 1'b0, '0},
        '{ROW_CFG, OP_AGE,      CFG_ACTIVE_SLOTS,    16'd2,    1'b0, '0},
        '{ROW_OP,  OP_ACTIVATE, CFG_ACTIVE_SLOTS,    16'h5A5A, 1'b1, '{ST_REJECT, 4'd0, 16'h0000, 1'b0}},
        '{ROW_CFG, OP_AGE,      CFG_EVICT_THRESHOLD, 16'd0,    1'b0, '0},
        '{ROW_OP,  OP_ACTIVATE, CFG_ACTIVE_SLOTS,    16'h5A5A, 1'b1, '{ST_EVICT,  4'd0, 16'h0000, 1'b1}},
        '{ROW_OP,  OP_AGE,      CFG_ACTIVE_SLOTS,    16'hFFFF, 1'b0, '0},
        '{ROW_OP,  OP_TOUCH,    CFG_ACTIVE_SLOTS,    16'h5A5A, 1'b0, '0},
        '{ROW_OP,  OP_ACTIVATE, CFG_ACTIVE_SLOTS,    16'h00FF, 1'b1, '{ST_EVICT,  4'd1, 16'hFFFF, 1'b1}},
        '{ROW_CFG, OP_AGE,      CFG_ACTIVE_SLOTS,    16'd0,    1'b0, '0},
        '{ROW_OP,  OP_TOUCH,    CFG_ACTIVE_SLOTS,    16'h5A5A, 1'b1, '{ST_MISS,   4'd0, 16'h0000, 1'b0}},
        '{ROW_OP,  OP_ACTIVATE, CFG_ACTIVE_SLOTS,    16'h1111, 1'b1, '{ST_REJECT, 4'd0, 16'h0000, 1'b0}},
        '{ROW_OP,  OP_AGE,      CFG_ACTIVE_SLOTS,    16'h0000, 1'b0, '0},
        '{ROW_CFG, OP_AGE,      CFG_ACTIVE_SLOTS,    16'd31,   1'b0, '0},
        '{ROW_OP,  OP_ACTIVATE, CFG_ACTIVE_SLOTS,    16'h00FF, 1'b0, '0},
        '{ROW_OP,  OP_ACTIVATE, CFG_ACTIVE_SLOTS,    16'h2222, 1'b0, '0},
        '{ROW_OP,  OP_CLEAR,    CFG_ACTIVE_SLOTS,    16'hFFFF, 1'b1, '{ST_DONE,   4'd0, 16'h0000, 1'b0}},
        '{ROW_OP,  OP_TOUCH,    CFG_ACTIVE_SLOTS,    16'h00FF, 1'b1, '{ST_MISS,   4'd0, 16'h0000, 1'b0}},
        '{ROW_OP,  OP_ACTIVATE, CFG_ACTIVE_SLOTS,    16'h3333, 1'b0, '0},
        '{ROW_CFG, OP_AGE,      CFG_ACTIVE_SLOTS,    16'd1,    1'b0, '0},
        '{ROW_OP,  OP_ACTIVATE, CFG_ACTIVE_SLOTS,    16'h4444, 1'b1, '{ST_REJECT, 4'd0, 16'h0000, 1'b0}},
        '{ROW_OP,  OP_AGE,      CFG_ACTIVE_SLOTS,    16'h0000, 1'b0, '0},
        '{ROW_OP,  OP_ACTIVATE, CFG_ACTIVE_SLOTS,    16'h4444, 1'b0, '0}
    };

    initial begin
        for (int i = 0; i < SLOTS; i++) begin
            tbl_id[i] = '0;
            tbl_valid[i] = 1'b0;
            tbl_age[i] = '0;
        end
    end

    // Applies one op to the shadow table and returns the result it produces.
    function automatic t_probe_res predict_op(input logic [1:0] op, input logic [15:0] id);
        t_probe_res res;
        int n;
        int hit;
        int vacant;
        int oldest;
        res = '0;
        n = (cfg_active > SLOTS) ? SLOTS : int'(cfg_active);
        hit = -1;
        vacant = -1;
        oldest = -1;
        for (int i = 0; i < n; i++) begin
            if (hit < 0 && tbl_valid[i] && tbl_id[i] == id) hit = i;
            if (vacant < 0 && !tbl_valid[i]) vacant = i;
            if (oldest < 0 || tbl_age[i] > tbl_age[oldest]) oldest = i;
        end
        case (op)
            OP_AGE: begin
                res.status = ST_DONE;
                for (int i = 0; i < n; i++)
                    if (tbl_age[i] != AGE_MAX) tbl_age[i] = tbl_age[i] + 1'b1;
            end
            OP_TOUCH: begin
                if (hit >= 0) begin
                    tbl_age[hit] = '0;
                    res.status = ST_HIT;
                    res.slot = 4'(hit);
                end else begin
                    res.status = ST_MISS;
                end
            end
            OP_ACTIVATE: begin
                if (hit >= 0) begin
                    res.status = ST_HELD;
                    res.slot = 4'(hit);
                end else if (vacant >= 0 || (oldest >= 0 && tbl_age[oldest] > cfg_thresh)) begin
                    if (vacant >= 0) begin
                        res.status = ST_FREE;
                        res.slot = 4'(vacant);
                    end else begin
                        res.status = ST_EVICT;
                        res.slot = 4'(oldest);
                        res.ev_probe = tbl_id[oldest];
                        res.ev_valid = 1'b1;
                        vacant = oldest;
                    end
                    tbl_id[vacant] = id;
                    tbl_valid[vacant] = 1'b1;
                    tbl_age[vacant] = '0;
                end else begin
                    res.status = ST_REJECT;
                end
            end
            OP_CLEAR: begin
                res.status = ST_DONE;
                for (int i = 0; i < SLOTS; i++) begin
                    tbl_valid[i] = 1'b0;
                    tbl_age[i] = '0;
                end
            end
        endcase
        return res;
    endfunction

    // Offer one beat; on acceptance queue its expected result.
    task automatic send_op(input logic [1:0] op, input logic [15:0] id,
                           input logic chk, input t_probe_res typed);
        t_probe_res res;
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_opcode <= op;
        i_probe_id <= id;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        res = predict_op(op, id);
        pending_res = {pending_res, (chk ? typed : res)};
        sent_cnt++;
    endtask

    // Drain the block, then write one register while it sits idle.
    task automatic write_reg(input logic idx, input logic [15:0] data);
        i_in_valid <= 1'b0;
        while (pending_res.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_ACTIVE_SLOTS) cfg_active = data[4:0];
        else cfg_thresh = data;
    endtask

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            if (err_cnt < MAX_PRINTS)
                $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
            err_cnt++;
        end
    endfunction

    // result beat checker
    always @(posedge i_clk) begin
        t_probe_res want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            rcvd_cnt++;
            if (pending_res.size() == 0) begin
                if (err_cnt < MAX_PRINTS)
                    $display("%0t: result beat with nothing expected, expected none, got status %0d",
                             $time, o_status);
                err_cnt++;
            end else begin
                want = pending_res.pop_front();
                check_field("status", want.status, o_status);
                check_field("slot", want.slot, o_slot);
                check_field("evicted_probe", want.ev_probe, o_evicted_probe);
                check_field("evicted_valid", want.ev_valid, o_evicted_valid);
            end
            case (o_status)
                ST_EVICT:  evict_cnt++;
                ST_REJECT: reject_cnt++;
                ST_HIT:    hit_cnt++;
                ST_FREE:   fill_cnt++;
                default: ;
            endcase
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else if (hold_seen != hold_req) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == STALL_LIMIT) begin
            $display("probe_slot_age_replacement: mismatch");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        logic [15:0] pool [20];
        int pool_n;
        int pick;
        logic [1:0] op;
        logic [15:0] id;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < DIR_ROWS; r++) begin
            if (dir_tab[r].kind == ROW_CFG) write_reg(dir_tab[r].cidx, dir_tab[r].val);
            else send_op(dir_tab[r].op, dir_tab[r].val, dir_tab[r].chk, dir_tab[r].res);
        end

        for (int p = 0; p < PHASES; p++) begin
            write_reg(CFG_ACTIVE_SLOTS, 16'(ph_active[p]));
            write_reg(CFG_EVICT_THRESHOLD, 16'(ph_thresh[p]));
            case (p % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 70; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 70; end
                default: begin send_idle_pct = 31; stall_pct = 31; end
            endcase
            // ids drawn from a small pool so touches hit and the table fills up
            pool_n = ((ph_active[p] > SLOTS) ? SLOTS : ph_active[p]) + 4;
            for (int i = 0; i < pool_n; i++) pool[i] = 16'($urandom);
            if (p == 4) hold_req++;
            for (int k = 0; k < ph_items[p]; k++) begin
                pick = $urandom_range(99);
                id = 16'($urandom);
                if (pick < 6) op = 2'($urandom_range(3));
                else if (pick < 28) op = OP_AGE;
                else if (pick < 52) op = OP_TOUCH;
                else if (pick < 98) op = OP_ACTIVATE;
                else op = OP_CLEAR;
                if (pick >= 6 && (op == OP_TOUCH || op == OP_ACTIVATE))
                    id = pool[$urandom_range(pool_n - 1)];
                send_op(op, id, 1'b0, '0);
            end
        end

        send_idle_pct = 0;
        stall_pct = 0;
        i_in_valid <= 1'b0;
        while (pending_res.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);

        $display("%0d ops: directed table plus %0d random phases of slot counts and thresholds; %0d results",
                 sent_cnt, PHASES, rcvd_cnt);
        $display("outcomes seen: %0d evictions, %0d rejects, %0d touch hits, %0d free fills",
                 evict_cnt, reject_cnt, hit_cnt, fill_cnt);
        if (err_cnt == 0)
            $display("probe_slot_age_replacement: match");
        else
            $display("probe_slot_age_replacement: mismatch");
        $finish;
    end

endmodule
